// File: rtl/btsq_pkg.sv
//------------------------------------------------------------------------------
// btsq_pkg
// Shared types and constants for the box table segment query block.
//------------------------------------------------------------------------------
package btsq_pkg;

    localparam int CFG_BITS   = 10;
    localparam int IDX_BITS   = 1;
    localparam int COORD_BITS = 12;

    // Request kinds
    localparam logic [1:0] KIND_PLACE = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_DEL   = 2'd2;
    localparam logic [1:0] KIND_SEG   = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_WIDTH  = 1'd0;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 1'd1;

    typedef struct packed {
        logic [1:0]            kind;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } req_t;

    typedef struct packed {
        logic       answer;
        logic       status;
        logic [6:0] box_count;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture request
        logic scan_rd;   // issue table read for current index
        logic eval;      // evaluate read entry
        logic div_start; // start divisions for current entry
        logic div_done_use; // fold division results
        logic finish;    // write back and report
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // current index is last slot
        logic hit;       // search terminates on this entry
        logic need_div;  // entry needs slope divisions
        logic div_busy;
    } dp_sts_t;

endpackage

// File: rtl/btsq_div.sv
//------------------------------------------------------------------------------
// btsq_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
//------------------------------------------------------------------------------
module btsq_div
    import btsq_pkg::*;
#(
    parameter int NB = 40,
    parameter int DB = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NB-1:0] num,
    input  logic signed [DB-1:0] den,
    output logic                 busy,
    output logic signed [NB-1:0] quo
);

    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] q_reg, q_next;
    logic [NB:0]   r_reg, r_next;
    logic [NB-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NB:0]   trial;

    // absolute values and one shift-subtract step
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[NB-1:0], q_reg[NB-1]};
        if (start)
        begin
            q_next    = num[NB-1] ? NB'(-num) : num;
            d_next    = den[DB-1] ? NB'(-{{(NB-DB){den[DB-1]}}, den})
                                  : NB'({{(NB-DB){1'b0}}, den});
            neg_next  = num[NB-1] ^ den[DB-1];
            r_next    = '0;
            cnt_next  = CB'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? NB'(-q_reg) : q_reg;

endmodule

// File: rtl/btsq_ctrl.sv
//------------------------------------------------------------------------------
// btsq_ctrl
// Sequencer: scans the table one slot per read, waits on divisions.
//------------------------------------------------------------------------------
module btsq_ctrl
    import btsq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EVAL = 6'b000100,
        S_DIVS = 6'b001000,
        S_DIVW = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.hit || (!sts.need_div && sts.last))
                    state_next = S_DONE;
                else if (sts.need_div)
                    state_next = S_DIVS;
                else
                    state_next = S_READ;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (!sts.div_busy)
                begin
                    cmd.div_done_use = 1'b1;
                    if (sts.hit || sts.last)
                        state_next = S_DONE;
                    else
                        state_next = S_READ;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_READ)
        else $error("request not taken");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE)
        else $error("done not followed by idle");

endmodule

// File: rtl/btsq_dp.sv
//------------------------------------------------------------------------------
// btsq_dp
// Datapath: corner memory, valid bits, per-entry tests and slope divisions.
//------------------------------------------------------------------------------
module btsq_dp
    import btsq_pkg::*;
#(
    parameter int MAX_BOXES  = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  req_t                req,
    input  logic [CFG_BITS-1:0] box_width,
    input  logic [CFG_BITS-1:0] box_height,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    output logic                done,
    output rsp_t                rsp
);

    localparam int AB = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNB = $clog2(MAX_BOXES + 1);
    localparam int VB = COORD_BITS + 3;              // signed work width
    localparam int NB = 2 * VB + 2;                  // dividend width
    localparam int DB = VB;                          // divisor width

    // corner memory, one read port registered
    logic [COORD_BITS-1:0] mem_x [MAX_BOXES];
    logic [COORD_BITS-1:0] mem_y [MAX_BOXES];
    logic [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic [MAX_BOXES-1:0]  valid_reg;
    logic [CNB-1:0]        count_reg;

    // request
    logic [1:0]            kind_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic [AB-1:0]         idx_reg;
    logic                  found_reg;
    logic [AB-1:0]         hit_idx_reg;
    logic                  ent_v_reg;
    logic                  ans_reg, st_reg, done_reg;
    logic [6:0]            cnt_out_reg;

    // registered geometry for division phase
    logic signed [VB-1:0]  lx_reg, hx_reg, ly_reg, hy_reg;
    logic                  divh_reg;

    logic signed [VB-1:0] sx, sy, ex, ey, dx, dy, lx, hx, ly, hy;
    logic signed [VB-1:0] slx, shx, sly, shy, hw;
    logic                 last;
    logic                 cand_hit, cand_div;

    assign sx = VB'(px_reg);
    assign sy = VB'(py_reg);
    assign ex = VB'(qx_reg);
    assign ey = VB'(qy_reg);
    assign dx = sx - ex;
    assign dy = sy - ey;
    assign slx = (sx < ex) ? sx : ex;
    assign shx = (sx < ex) ? ex : sx;
    assign sly = (sy < ey) ? sy : ey;
    assign shy = (sy < ey) ? ey : sy;
    assign lx = VB'(rd_x_reg);
    assign ly = VB'(rd_y_reg);
    assign hx = lx + VB'(box_width);
    assign hy = ly + VB'(box_height);
    assign hw = VB'(box_width[CFG_BITS-1:1]);
    assign last = (idx_reg == AB'(MAX_BOXES - 1));

    // per-entry test on the read entry
    always_comb
    begin
        cand_hit = 1'b0;
        cand_div = 1'b0;
        case (kind_reg)
            KIND_PLACE:
                cand_hit = ent_v_reg && lx >= sx - hw && lx <= sx + hw &&
                           ly >= sy - hw && ly <= sy + hw;
            KIND_ADD:
                cand_hit = !ent_v_reg;
            KIND_DEL:
                cand_hit = ent_v_reg && rd_x_reg == px_reg && rd_y_reg == py_reg;
            KIND_SEG:
            begin
                if (!ent_v_reg)
                    cand_hit = 1'b0;
                else if (dx == '0)
                    cand_hit = sx >= lx && sx <= hx && ly <= shy && hy >= sly;
                else if (!(lx > shx || ly > shy || hx < slx || hy < sly))
                begin
                    if ((sx >= lx && sx <= hx && sy >= ly && sy <= hy) ||
                        (ex >= lx && ex <= hx && ey >= ly && ey <= hy))
                        cand_hit = 1'b1;
                    else
                        cand_div = 1'b1;
                end
            end
            default:
                cand_hit = 1'b0;
        endcase
    end

    // four dividers share a start: two vertical borders, two horizontal
    logic signed [NB-1:0] n0, n1, n2, n3, q0, q1, q2, q3;
    logic b0, b1, b2, b3;
    logic div_hit;

    assign n0 = NB'(sy) * NB'(dx) + NB'(lx_reg - sx) * NB'(dy);
    assign n1 = NB'(sy) * NB'(dx) + NB'(hx_reg - sx) * NB'(dy);
    assign n2 = NB'(sx) * NB'(dy) + NB'(ly_reg - sy) * NB'(dx);
    assign n3 = NB'(sx) * NB'(dy) + NB'(hy_reg - sy) * NB'(dx);

    btsq_div #(.NB(NB), .DB(DB)) u_d0 (.clk, .rst_n, .start(cmd.div_start),
        .num(n0), .den(dx), .busy(b0), .quo(q0));
    btsq_div #(.NB(NB), .DB(DB)) u_d1 (.clk, .rst_n, .start(cmd.div_start),
        .num(n1), .den(dx), .busy(b1), .quo(q1));
    btsq_div #(.NB(NB), .DB(DB)) u_d2 (.clk, .rst_n, .start(cmd.div_start),
        .num(n2), .den(divh_reg ? dy : VB'(1)), .busy(b2), .quo(q2));
    btsq_div #(.NB(NB), .DB(DB)) u_d3 (.clk, .rst_n, .start(cmd.div_start),
        .num(n3), .den(divh_reg ? dy : VB'(1)), .busy(b3), .quo(q3));

    always_comb
    begin
        div_hit =
            (q0 >= NB'(ly_reg) && q0 <= NB'(hy_reg) && lx_reg >= slx && lx_reg <= shx) ||
            (q1 >= NB'(ly_reg) && q1 <= NB'(hy_reg) && hx_reg >= slx && hx_reg <= shx) ||
            (divh_reg && q2 >= NB'(lx_reg) && q2 <= NB'(hx_reg) &&
             ly_reg >= sly && ly_reg <= shy) ||
            (divh_reg && q3 >= NB'(lx_reg) && q3 <= NB'(hx_reg) &&
             hy_reg >= sly && hy_reg <= shy);
    end

    assign sts.last     = last;
    assign sts.hit      = cmd.div_done_use ? div_hit : cand_hit;
    assign sts.need_div = cand_div;
    assign sts.div_busy = b0 | b1 | b2 | b3;

    // result of the search for each kind
    logic res_found;
    assign res_found = found_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.kind;
            px_reg   <= req.pos_x[COORD_BITS-1:0];
            py_reg   <= req.pos_y[COORD_BITS-1:0];
            qx_reg   <= req.end_x[COORD_BITS-1:0];
            qy_reg   <= req.end_y[COORD_BITS-1:0];
        end
        if (cmd.scan_rd)
        begin
            rd_x_reg  <= mem_x[idx_reg];
            rd_y_reg  <= mem_y[idx_reg];
            ent_v_reg <= valid_reg[idx_reg];
        end
        if (cmd.eval)
        begin
            lx_reg   <= lx;
            hx_reg   <= hx;
            ly_reg   <= ly;
            hy_reg   <= hy;
            divh_reg <= (dy != '0);
        end
        if (cmd.eval && cand_hit)
            hit_idx_reg <= idx_reg;
        if (cmd.finish && kind_reg == KIND_ADD && found_reg)
        begin
            mem_x[hit_idx_reg] <= px_reg;
            mem_y[hit_idx_reg] <= py_reg;
        end
    end

    // control state: index, found flag, valid bits, count, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            ans_reg     <= 1'b0;
            st_reg      <= 1'b0;
            cnt_out_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if ((cmd.eval && !cand_div) || cmd.div_done_use)
            begin
                if (sts.hit)
                    found_reg <= 1'b1;
                else if (!last)
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                st_reg <= 1'b0;
                case (kind_reg)
                    KIND_PLACE: ans_reg <= !res_found;
                    KIND_ADD:
                    begin
                        ans_reg <= res_found;
                        st_reg  <= !res_found;
                        if (res_found)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    KIND_DEL:
                    begin
                        ans_reg <= res_found;
                        if (res_found)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                    default: ans_reg <= res_found;
                endcase
                case (kind_reg)
                    KIND_ADD: cnt_out_reg <= 7'(count_reg + CNB'(res_found));
                    KIND_DEL: cnt_out_reg <= 7'(count_reg - CNB'(res_found));
                    default:  cnt_out_reg <= 7'(count_reg);
                endcase
            end
        end
    end

    assign done          = done_reg;
    assign rsp.answer    = ans_reg;
    assign rsp.status    = st_reg;
    assign rsp.box_count = cnt_out_reg;

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNB'($countones(valid_reg)))
        else $error("count disagrees with valid bits");
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp.status) |-> !rsp.answer)
        else $error("full add reported as accepted");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> sts.div_busy)
        else $error("divider did not start");

endmodule

// File: rtl/box_table_segment_query_core.sv
//------------------------------------------------------------------------------
// box_table_segment_query_core
// Box table with placement, add, delete and segment-hit requests.
//------------------------------------------------------------------------------
// Usage:
//   Raise start with a request on req while busy is low; it is taken at that
//   edge. One result appears on rsp with done high for a single cycle. The
//   receiver cannot stall; it must take the result in that cycle.
//   Configuration: cfg_we, cfg_idx, cfg_data write box_width (0) or
//   box_height (1); write only while busy is low.
// Sequencing: the controller reads one table slot at a time, in a read state
//   then a test state, stopping at the first hit; done is registered from the
//   done state. Each segment entry that passes the coarse box test adds a
//   division pass through the bit-serial dividers. busy is already low in
//   the done cycle, so the next request can be taken at the edge that ends it.
// Reset: the table is empty, the count zero, both registers 32. No clearing
//   pass is needed.
//------------------------------------------------------------------------------
module box_table_segment_query_core
    import btsq_pkg::*;
#(
    parameter int MAX_BOXES  = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  req_t                req,
    output logic                busy,
    output logic                done,
    output rsp_t                rsp,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_idx,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic [CFG_BITS-1:0] width_reg, height_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    ctl_busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_BITS'(32);
            height_reg <= CFG_BITS'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    btsq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctl_busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    btsq_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .box_width  (width_reg),
        .box_height (height_reg),
        .cmd        (cmd),
        .sts        (sts),
        .done       (done),
        .rsp        (rsp)
    );

    assign busy = ctl_busy;

endmodule
